/* hdl/scfr_pkg.sv */
// ----------------------------------------------------------------------------
// Serial command frame receiver package
// Frame constants, status codes and widths shared by the receiver files.
// ----------------------------------------------------------------------------
package scfr_pkg;

   localparam int unsigned PAYLOAD_BYTES = 6;
   localparam int unsigned TIMEOUT_W     = 20;
   localparam int unsigned SUM_W         = 11;

   localparam logic [7:0]  SYNC_BYTE     = 8'h7E;
   localparam logic [7:0]  END_BYTE      = 8'hEF;
   localparam logic [7:0]  GOOD_LENGTH   = 8'd6;
   localparam logic [SUM_W-1:0] SUM_BASE = SUM_W'(16'h00FF + 16'd6);

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(2082);

   typedef logic [1:0] status_type;
   localparam status_type ST_OK         = 2'd0;
   localparam status_type ST_BAD_LENGTH = 2'd1;
   localparam status_type ST_CHECKSUM   = 2'd2;
   localparam status_type ST_TIMEOUT    = 2'd3;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef struct packed {
      logic [7:0] command_code;
      logic       wants_feedback;
      logic [7:0] param_high;
      logic [7:0] param_low;
      logic [7:0] sum_high;
      logic [7:0] sum_low;
   } frame_type;

endpackage

/* hdl/scfr_checksum.sv */
// ----------------------------------------------------------------------------
// Frame checksum compare
// Forms 0x10000 minus the frame sum and compares it with the received word.
// ----------------------------------------------------------------------------
module scfr_checksum (
   input  scfr_pkg::frame_type frame,
   output logic                match
);
   import scfr_pkg::*;

   logic [SUM_W-1:0] total;
   logic [15:0]      expected;

   assign total = SUM_BASE + SUM_W'(frame.command_code)
                + SUM_W'(frame.wants_feedback)
                + SUM_W'(frame.param_high) + SUM_W'(frame.param_low);
   assign expected = 16'h0000 - 16'(total);
   assign match    = (expected == {frame.sum_high, frame.sum_low});

endmodule

/* hdl/serial_command_frame_receiver.sv */
// ----------------------------------------------------------------------------
// Serial command frame receiver
// Hunts for sync, reads version and length, keeps six payload bytes, checks
// the checksum and trailer, and aborts a frame on an inter-byte timeout.
// ----------------------------------------------------------------------------
// A result is registered and appears on rsp_ in the cycle after the beat that causes it.
// Throughput: one req_ beat per cycle; req_stall rises only while a result
//   is held and rsp_stall is high (single output register).
// Reset (synchronous): phase back to sync hunt, counters cleared, result
//   register emptied, byte timeout limit set to 2082 ticks.
module serial_command_frame_receiver (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_opcode,
   input  logic [7:0]                          req_data_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic [7:0]                          rsp_command_code,
   output logic                                rsp_wants_feedback,
   output logic [7:0]                          rsp_param_high,
   output logic [7:0]                          rsp_param_low,
   output logic                                rsp_end_ok,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [scfr_pkg::TIMEOUT_W-1:0]      csr_data
);
   import scfr_pkg::*;

   localparam logic [2:0] PH_HUNT    = 3'd0;
   localparam logic [2:0] PH_VERSION = 3'd1;
   localparam logic [2:0] PH_LENGTH  = 3'd2;
   localparam logic [2:0] PH_PAYLOAD = 3'd3;
   localparam logic [2:0] PH_TRAILER = 3'd4;

   logic [2:0]           phase_ff, phase_in;
   logic [7:0]           length_ff, length_in;
   logic [7:0]           taken_ff, taken_in;
   logic [TIMEOUT_W-1:0] idle_ff, idle_in;
   logic [TIMEOUT_W-1:0] limit_ff;
   logic [7:0]           store_ff [PAYLOAD_BYTES];

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           status_ff;
   logic [7:0]           cmd_ff, p1_ff, p2_ff;
   logic                 fb_ff, end_ok_ff;

   logic                 accept;
   logic                 emit;
   logic                 with_payload;
   status_type           emit_status;
   logic                 emit_end_ok;
   logic                 store_we;
   logic [7:0]           taken_next;
   logic                 sum_match;
   frame_type            frame;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign taken_next = taken_ff + 8'd1;

   assign frame.command_code   = store_ff[0];
   assign frame.wants_feedback = (store_ff[1] != 8'd0);
   assign frame.param_high     = store_ff[2];
   assign frame.param_low      = store_ff[3];
   assign frame.sum_high       = store_ff[4];
   assign frame.sum_low        = req_data_byte;

   scfr_checksum u_checksum (
      .frame (frame),
      .match (sum_match)
   );

   always_comb begin
      phase_in     = phase_ff;
      length_in    = length_ff;
      taken_in     = taken_ff;
      idle_in      = idle_ff;
      emit         = 1'b0;
      with_payload = 1'b0;
      emit_status  = ST_OK;
      emit_end_ok  = 1'b0;
      store_we     = 1'b0;
      if (req_opcode == OP_TICK) begin
         if (phase_ff != PH_HUNT) begin
            if (idle_ff >= limit_ff) begin
               phase_in    = PH_HUNT;
               idle_in     = '0;
               emit        = 1'b1;
               emit_status = ST_TIMEOUT;
            end else begin
               idle_in = idle_ff + TIMEOUT_W'(1);
            end
         end
      end else begin
         idle_in = '0;
         unique case (phase_ff)
            PH_HUNT: begin
               if (req_data_byte == SYNC_BYTE) phase_in = PH_VERSION;
            end
            PH_VERSION: begin
               phase_in = PH_LENGTH;
            end
            PH_LENGTH: begin
               length_in = req_data_byte;
               taken_in  = '0;
               if (req_data_byte == 8'd0) begin
                  phase_in    = PH_HUNT;
                  emit        = 1'b1;
                  emit_status = ST_BAD_LENGTH;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               store_we = (taken_ff < 8'(PAYLOAD_BYTES));
               taken_in = taken_next;
               if (taken_next == length_ff) begin
                  phase_in = PH_HUNT;
                  if (length_ff != GOOD_LENGTH) begin
                     emit        = 1'b1;
                     emit_status = ST_BAD_LENGTH;
                  end else if (!sum_match) begin
                     emit         = 1'b1;
                     emit_status  = ST_CHECKSUM;
                     with_payload = 1'b1;
                  end else begin
                     phase_in = PH_TRAILER;
                  end
               end
            end
            PH_TRAILER: begin
               phase_in     = PH_HUNT;
               emit         = 1'b1;
               emit_status  = ST_OK;
               with_payload = 1'b1;
               emit_end_ok  = (req_data_byte == END_BYTE);
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   always_comb begin
      if (accept && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         length_ff    <= '0;
         taken_ff     <= '0;
         idle_ff      <= '0;
         limit_ff     <= TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) limit_ff <= csr_data;
         if (accept) begin
            phase_ff  <= phase_in;
            length_ff <= length_in;
            taken_ff  <= taken_in;
            idle_ff   <= idle_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && store_we) store_ff[taken_ff[2:0]] <= req_data_byte;
      if (accept && emit) begin
         status_ff <= emit_status;
         end_ok_ff <= emit_end_ok;
         cmd_ff    <= with_payload ? frame.command_code : 8'd0;
         fb_ff     <= with_payload ? frame.wants_feedback : 1'b0;
         p1_ff     <= with_payload ? frame.param_high : 8'd0;
         p2_ff     <= with_payload ? frame.param_low : 8'd0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_command_code   = cmd_ff;
   assign rsp_wants_feedback = fb_ff;
   assign rsp_param_high     = p1_ff;
   assign rsp_param_low      = p2_ff;
   assign rsp_end_ok         = end_ok_ff;

endmodule

/* hdl/scfr_checker.sv */
// ----------------------------------------------------------------------------
// Serial command frame receiver checker
// Port-level properties of the receiver, bound into the receiver module.
// ----------------------------------------------------------------------------
module scfr_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [1:0]                     rsp_status,
   input logic [7:0]                     rsp_command_code,
   input logic                           rsp_wants_feedback,
   input logic [7:0]                     rsp_param_high,
   input logic [7:0]                     rsp_param_low,
   input logic                           rsp_end_ok
);
   import scfr_pkg::*;

   a_held_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_command_code) && $stable(rsp_param_high)
         && $stable(rsp_param_low) && $stable(rsp_end_ok))
      else $error("held result beat changed");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a blocked result");

   a_end_ok_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> !rsp_end_ok)
      else $error("end_ok set on a failed frame");

   a_empty_abort: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_BAD_LENGTH || rsp_status == ST_TIMEOUT)
         |-> rsp_command_code == 8'd0 && !rsp_wants_feedback
            && rsp_param_high == 8'd0 && rsp_param_low == 8'd0)
      else $error("payload shown on an aborted frame");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind serial_command_frame_receiver scfr_checker u_scfr_checker (.*);

/* dv/serial_command_frame_checker.sv */
// ----------------------------------------------------------------------------
// Serial command frame checker
// Watches the byte/tick, result and limit channels of the frame receiver,
// tracks the frame state on its own, queues the report each accepted beat
// should cause and compares every result beat against the oldest one.
// ----------------------------------------------------------------------------
module serial_command_frame_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic                           req_opcode,
   input  logic [7:0]                     req_data_byte,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [1:0]                     rsp_status,
   input  logic [7:0]                     rsp_command_code,
   input  logic                           rsp_wants_feedback,
   input  logic [7:0]                     rsp_param_high,
   input  logic [7:0]                     rsp_param_low,
   input  logic                           rsp_end_ok,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [scfr_pkg::TIMEOUT_W-1:0] csr_data,
   output int                             mismatch_count,
   output int                             outstanding
);
   import scfr_pkg::*;

   typedef enum logic [2:0] {
      RX_HUNT,
      RX_VERSION,
      RX_LENGTH,
      RX_PAYLOAD,
      RX_TRAILER
   } rx_phase_type;

   typedef struct packed {
      status_type status;
      logic [7:0] command_code;
      logic       wants_feedback;
      logic [7:0] param_high;
      logic [7:0] param_low;
      logic       end_ok;
   } frame_report_type;

   rx_phase_type         rx_phase;
   logic [TIMEOUT_W-1:0] tick_limit;
   logic [TIMEOUT_W-1:0] tick_count;
   logic [7:0]           frame_len;
   logic [7:0]           taken;
   logic [7:0]           held [PAYLOAD_BYTES];
   frame_report_type     pending_reports [$];
   int                   mismatches;

   function automatic frame_report_type make_report(input status_type st,
                                                    input bit with_payload,
                                                    input logic eok);
      frame_report_type rpt;
      rpt = '0;
      rpt.status = st;
      if (with_payload) begin
         rpt.command_code   = held[0];
         rpt.wants_feedback = (held[1] != 8'h00);
         rpt.param_high     = held[2];
         rpt.param_low      = held[3];
      end
      rpt.end_ok = eok;
      return rpt;
   endfunction

   function automatic bit absorb_beat(input logic op, input logic [7:0] b,
                                      output frame_report_type rpt);
      logic [15:0] sum;
      rpt = '0;
      if (op == OP_TICK) begin
         if (rx_phase == RX_HUNT) return 1'b0;
         if (tick_count >= tick_limit) begin
            rx_phase   = RX_HUNT;
            tick_count = '0;
            rpt        = make_report(ST_TIMEOUT, 1'b0, 1'b0);
            return 1'b1;
         end
         tick_count = tick_count + 1'b1;
         return 1'b0;
      end
      tick_count = '0;
      case (rx_phase)
         RX_HUNT: begin
            if (b == SYNC_BYTE) rx_phase = RX_VERSION;
            return 1'b0;
         end
         RX_VERSION: begin
            rx_phase = RX_LENGTH;
            return 1'b0;
         end
         RX_LENGTH: begin
            frame_len = b;
            taken     = 8'd0;
            if (b == 8'd0) begin
               rx_phase = RX_HUNT;
               rpt      = make_report(ST_BAD_LENGTH, 1'b0, 1'b0);
               return 1'b1;
            end
            rx_phase = RX_PAYLOAD;
            return 1'b0;
         end
         RX_PAYLOAD: begin
            if (taken < PAYLOAD_BYTES) held[taken] = b;
            taken = taken + 8'd1;
            if (taken < frame_len) return 1'b0;
            rx_phase = RX_HUNT;
            if (frame_len != GOOD_LENGTH) begin
               rpt = make_report(ST_BAD_LENGTH, 1'b0, 1'b0);
               return 1'b1;
            end
            sum = 16'h0000 - (16'h00FF + 16'(GOOD_LENGTH) + 16'(held[0])
                  + 16'(held[1] != 8'h00) + 16'(held[2]) + 16'(held[3]));
            if (sum != {held[4], held[5]}) begin
               rpt = make_report(ST_CHECKSUM, 1'b1, 1'b0);
               return 1'b1;
            end
            rx_phase = RX_TRAILER;
            return 1'b0;
         end
         RX_TRAILER: begin
            rx_phase = RX_HUNT;
            rpt      = make_report(ST_OK, 1'b1, b == END_BYTE);
            return 1'b1;
         end
         default: begin
            rx_phase = RX_HUNT;
            return 1'b0;
         end
      endcase
   endfunction

   function automatic int check_field(input string name, input int unsigned want,
                                      input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      frame_report_type rpt;
      frame_report_type want;
      if (reset) begin
         rx_phase   = RX_HUNT;
         tick_limit = TIMEOUT_RESET;
         tick_count = '0;
         frame_len  = 8'd0;
         taken      = 8'd0;
         for (int i = 0; i < PAYLOAD_BYTES; i++) held[i] = 8'h00;
         pending_reports.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_reports.size() == 0) begin
               $error("result beat with no frame report pending");
               mismatches++;
            end else begin
               want = pending_reports.pop_front();
               mismatches += check_field("rsp_status", want.status, rsp_status);
               mismatches += check_field("rsp_command_code", want.command_code,
                                         rsp_command_code);
               mismatches += check_field("rsp_wants_feedback", want.wants_feedback,
                                         rsp_wants_feedback);
               mismatches += check_field("rsp_param_high", want.param_high,
                                         rsp_param_high);
               mismatches += check_field("rsp_param_low", want.param_low, rsp_param_low);
               mismatches += check_field("rsp_end_ok", want.end_ok, rsp_end_ok);
            end
         end
         if (req_valid && !req_stall && absorb_beat(req_opcode, req_data_byte, rpt))
            pending_reports.push_back(rpt);
         if (csr_valid && csr_ready) tick_limit = csr_data;
      end
      outstanding    <= pending_reports.size();
      mismatch_count <= mismatches;
   end

endmodule

/* dv/serial_command_frame_receiver_tb.sv */
// ----------------------------------------------------------------------------
// Serial command frame receiver testbench
// Drives byte and tick beats with random gaps and result stalls: a directed
// set of frames first, then random frames (good, bad checksum, bad length,
// truncated, noise) under several byte timeout limits from 0 to the maximum.
// ----------------------------------------------------------------------------
module serial_command_frame_receiver_tb;
   import scfr_pkg::*;

   localparam int unsigned ITEM_TARGET = 1450;
   localparam int unsigned STALL_LIMIT = 2000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_opcode;
   logic [7:0]           req_data_byte;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [1:0]           rsp_status;
   logic [7:0]           rsp_command_code;
   logic                 rsp_wants_feedback;
   logic [7:0]           rsp_param_high;
   logic [7:0]           rsp_param_low;
   logic                 rsp_end_ok;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [TIMEOUT_W-1:0] csr_data;

   int                   mismatch_count;
   int                   outstanding;
   bit                   quiet;
   int unsigned          beats_sent;
   logic [TIMEOUT_W-1:0] limit_now;

   serial_command_frame_receiver dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_command_code   (rsp_command_code),
      .rsp_wants_feedback (rsp_wants_feedback),
      .rsp_param_high     (rsp_param_high),
      .rsp_param_low      (rsp_param_low),
      .rsp_end_ok         (rsp_end_ok),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data)
   );

   serial_command_frame_checker frame_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_command_code   (rsp_command_code),
      .rsp_wants_feedback (rsp_wants_feedback),
      .rsp_param_high     (rsp_param_high),
      .rsp_param_low      (rsp_param_low),
      .rsp_end_ok         (rsp_end_ok),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data),
      .mismatch_count     (mismatch_count),
      .outstanding        (outstanding)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 33);
   end

   initial begin
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("status: fail");
      $finish;
   end

   function automatic logic [15:0] frame_sum(input logic [7:0] cmd, input logic [7:0] fb,
                                             input logic [7:0] p1, input logic [7:0] p2);
      return 16'h0000 - (16'h00FF + 16'(GOOD_LENGTH) + 16'(cmd) + 16'(fb != 8'h00)
             + 16'(p1) + 16'(p2));
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned cap;
      int unsigned r;
      cap = (limit_now < 40) ? int'(limit_now) : 40;
      r   = $urandom_range(0, 19);
      if (r == 0) return $urandom_range(0, (cap < 8) ? cap : 8);
      if (r == 1) return cap;
      if (r == 2) return (limit_now < 40) ? int'(limit_now) + 1 : 40;
      return 0;
   endfunction

   task automatic put_beat(input logic op, input logic [7:0] b, input bit counted);
      while (!quiet && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      if (counted) beats_sent++;
   endtask

   task automatic put_frame_byte(input logic [7:0] b);
      repeat (pick_gap()) put_beat(OP_TICK, 8'($urandom), 1'b1);
      put_beat(OP_BYTE, b, 1'b1);
   endtask

   task automatic put_bytes(input logic [7:0] seq [$]);
      foreach (seq[i]) put_beat(OP_BYTE, seq[i], 1'b1);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_limit(input logic [TIMEOUT_W-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      limit_now = value;
   endtask

   task automatic send_frame();
      logic [7:0]  cmd;
      logic [7:0]  fb;
      logic [7:0]  p1;
      logic [7:0]  p2;
      logic [7:0]  len;
      logic [15:0] sum;
      int unsigned kind;
      cmd  = 8'($urandom);
      fb   = $urandom_range(0, 1) ? 8'h00 : 8'($urandom);
      p1   = 8'($urandom);
      p2   = 8'($urandom);
      sum  = frame_sum(cmd, fb, p1, p2);
      kind = $urandom_range(0, 99);
      if (kind >= 90) begin
         repeat ($urandom_range(1, 4)) put_beat(OP_BYTE, 8'($urandom), 1'b0);
         return;
      end
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 3)) put_beat(OP_TICK, 8'($urandom), 1'b0);
      put_frame_byte(SYNC_BYTE);
      put_frame_byte(8'($urandom));
      if (kind < 65) begin
         if (kind >= 50) sum = sum ^ 16'($urandom_range(1, 16'hFFFF));
         put_frame_byte(GOOD_LENGTH);
         put_frame_byte(cmd);
         put_frame_byte(fb);
         put_frame_byte(p1);
         put_frame_byte(p2);
         put_frame_byte(sum[15:8]);
         put_frame_byte(sum[7:0]);
         if (kind < 50) put_frame_byte($urandom_range(0, 1) ? END_BYTE : 8'($urandom));
      end else if (kind < 80) begin
         len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(13, 255))
                                           : 8'($urandom_range(0, 12));
         if (len == GOOD_LENGTH) len = GOOD_LENGTH + 8'd1;
         put_frame_byte(len);
         repeat (len) put_frame_byte(8'($urandom));
      end else begin
         repeat ($urandom_range(0, 8)) put_frame_byte(8'($urandom));
         if (limit_now < 40)
            repeat (limit_now + 1) put_beat(OP_TICK, 8'($urandom), 1'b1);
      end
   endtask

   initial begin
      logic [TIMEOUT_W-1:0] limits [6];
      logic [15:0]          sum;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_opcode    <= OP_BYTE;
      req_data_byte <= 8'h00;
      csr_valid     <= 1'b0;
      csr_data      <= '0;
      quiet         <= 1'b0;
      beats_sent    = 0;
      limit_now     = TIMEOUT_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      put_beat(OP_TICK, 8'hFF, 1'b0);
      put_beat(OP_BYTE, 8'h00, 1'b0);
      sum = frame_sum(8'hFF, 8'h00, 8'h00, 8'hFF);
      put_bytes('{SYNC_BYTE, 8'h01, GOOD_LENGTH, 8'hFF});
      put_beat(OP_TICK, 8'h00, 1'b1);
      put_bytes('{8'h00, 8'h00, 8'hFF, sum[15:8], sum[7:0], END_BYTE});
      put_bytes('{SYNC_BYTE, 8'h00, 8'h00});
      put_bytes('{SYNC_BYTE, 8'hFF, GOOD_LENGTH, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h00});
      set_limit('0);
      put_bytes('{SYNC_BYTE, 8'h00});
      put_beat(OP_TICK, 8'hFF, 1'b1);

      limits = '{'0, 20'd1, 20'd5, 20'($urandom_range(2, 30)), 20'hFFFFF, 20'd3};
      for (int i = 0; i < 6; i++) begin
         if (i > 0) set_limit(limits[i]);
         quiet <= (i == 3);
         while (beats_sent < ITEM_TARGET * (i + 1) / 6) send_frame();
      end

      drain();
      quiet <= 1'b0;
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
